FILE: src/wbh_pkg.sv
// Shared types and constants for the weighted batched histogram.
// No dependencies; imported by wbh_div and weighted_batched_histogram.
package wbh_pkg;

	localparam int MAX_BINS  = 32;
	localparam int MAX_BATCH = 16;
	localparam int BIN_AW    = $clog2(MAX_BINS);
	localparam int PEND_AW   = $clog2(MAX_BATCH);
	localparam int BIN_W     = 48;
	localparam int DVD_W     = 49;
	localparam int DEN_W     = 37;
	localparam int CFG_IW    = 3;

	localparam logic signed [BIN_W-1:0] BIN_MAXV = {1'b0, {(BIN_W-1){1'b1}}};
	localparam logic signed [BIN_W-1:0] BIN_MINV = {1'b1, {(BIN_W-1){1'b0}}};

	localparam logic [CFG_IW-1:0] CFG_RANGE_MIN = 3'd0;
	localparam logic [CFG_IW-1:0] CFG_BIN_WIDTH = 3'd1;
	localparam logic [CFG_IW-1:0] CFG_BINS      = 3'd2;
	localparam logic [CFG_IW-1:0] CFG_BATCH     = 3'd3;
	localparam logic [CFG_IW-1:0] CFG_NORMALIZE = 3'd4;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SC_RD,
		ST_SC_LD,
		ST_SC_DIV,
		ST_SC_WR,
		ST_BC,
		ST_PD_RD,
		ST_PD_LD,
		ST_SEARCH,
		ST_AD_DIV,
		ST_BN_RD,
		ST_BN_WR,
		ST_OUT_RD,
		ST_OUT_LD
	} state_t;

	typedef struct packed {
		logic                    start;
		logic signed [DVD_W-1:0] num;
		logic [DEN_W-1:0]        den;
	} div_req_t;

	typedef struct packed {
		logic                    done;
		logic signed [DVD_W-1:0] quo;
	} div_rsp_t;

endpackage

FILE: src/weighted_batched_histogram.sv
// Weighted batched histogram, top level: buffers, bin store, flush sequencer.
// Depends on wbh_pkg and wbh_div.
//
//  channel  | signals                        | payload
//  ---------+--------------------------------+----------------------------------
//  in       | s_axis_tvalid/tready/tdata     | sample, weight
//  out      | m_axis_tvalid/tready/tdata/tlast| bin_index, bin_value, batches_done
//  config   | cfg_valid/ready/index/data     | register index, value
//
// A request that does not complete a batch only buffers its sample. With normalize
// set, a flush first rescales every bin through the divider; then, for each buffered
// sample, it searches the bin in up to 5 halvings, divides the weight (normalize set
// only), adds it to the bin and last streams out every bin. Each division: 49 serial steps.
// Reset clears the bin valid bits, the fill and batch counters; no clearing pass.
// Input is taken only while idle; output stalls hold the sequencer in place.
module weighted_batched_histogram (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [63:0]                s_axis_tdata,  // sample[31:0], weight[63:32]
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	output logic [87:0]                m_axis_tdata,  // bin_index[4:0], bin_value[52:5],
	                                                  // batches_done[84:53], zero pad
	output logic                       m_axis_tlast,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [wbh_pkg::CFG_IW-1:0] cfg_index,
	input  logic [31:0]                cfg_data
);
	import wbh_pkg::*;

	// configuration
	logic signed [31:0] range_min_q;
	logic [30:0]        bin_width_q;
	logic [5:0]         bins_q;
	logic [4:0]         batch_q;
	logic               norm_q;

	// control
	state_t            state_q, state_d;
	logic [4:0]        fill_q;
	logic [31:0]       bc_q;
	logic [5:0]        i_q;
	logic [4:0]        j_q;
	logic [5:0]        lo_q, hi_q;
	logic signed [38:0] elo_q;
	logic              m_valid_q;

	// payload
	logic signed [31:0]      smp_q, wgt_q;
	logic signed [BIN_W-1:0] acc_q;
	logic signed [DVD_W-1:0] add_q;
	logic [DEN_W-1:0]        den_q;
	logic [87:0]             m_data_q;
	logic                    m_last_q;

	// memories
	logic [BIN_W-1:0]  bin_mem [MAX_BINS];
	logic [MAX_BINS-1:0] bin_vld_q;
	logic [BIN_W-1:0]  bin_rdata_s1;
	logic              bin_rvld_s1;
	logic [63:0]       pend_mem [MAX_BATCH];
	logic [63:0]       pend_rdata_s1;

	// datapath
	logic [5:0]        n_eff;
	logic [4:0]        b_eff;
	logic              in_acc, cfg_acc;
	logic [4:0]        fill_nx;
	logic              flush;
	logic              out_free;
	logic              last_bin;
	logic signed [BIN_W-1:0] bval;
	logic [5:0]        mid;
	logic [36:0]       prod;
	logic signed [38:0] e_mid, x39;
	logic              go_low;
	logic signed [49:0] sum;
	logic signed [BIN_W-1:0] sat_sum;
	logic signed [DVD_W-1:0] scaled;
	logic [31:0]       bc_inc;

	// sequencer outputs
	logic [BIN_AW-1:0]  bin_raddr;
	logic               bin_we;
	logic [BIN_AW-1:0]  bin_waddr;
	logic [BIN_W-1:0]   bin_wdata;
	logic [PEND_AW-1:0] pend_raddr;
	logic               out_load;
	div_req_t           div_req;
	div_rsp_t           div_rsp;

	wbh_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign n_eff = (bins_q == 6'd0) ? 6'd1 :
		(bins_q > 6'(MAX_BINS)) ? 6'(MAX_BINS) : bins_q;
	assign b_eff = (batch_q == 5'd0) ? 5'd1 :
		(batch_q > 5'(MAX_BATCH)) ? 5'(MAX_BATCH) : batch_q;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready     = 1'b1;
	assign in_acc        = s_axis_tvalid && s_axis_tready;
	assign cfg_acc       = cfg_valid && cfg_ready;
	assign fill_nx       = (fill_q < 5'(MAX_BATCH)) ? fill_q + 5'd1 : fill_q;
	assign flush         = fill_nx >= b_eff;
	assign out_free      = !m_valid_q || m_axis_tready;
	assign last_bin      = (i_q + 6'd1) == n_eff;

	assign bval    = bin_rvld_s1 ? $signed(bin_rdata_s1) : '0;
	assign mid     = lo_q + ((hi_q - lo_q) >> 1);
	assign prod    = bin_width_q * mid;
	assign e_mid   = 39'(range_min_q) + $signed({2'b00, prod});
	assign x39     = 39'(smp_q);
	assign go_low  = (elo_q <= x39) && (x39 <= e_mid);
	assign sum     = 50'(bval) + 50'(add_q);
	assign sat_sum = (sum > 50'(BIN_MAXV)) ? BIN_MAXV :
		(sum < 50'(BIN_MINV)) ? BIN_MINV : sum[BIN_W-1:0];
	assign scaled  = DVD_W'(acc_q) - div_rsp.quo;
	assign bc_inc  = (bc_q == 32'hFFFF_FFFF) ? bc_q : bc_q + 32'd1;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && flush)
					state_d = norm_q ? ST_SC_RD : ST_BC;
			end
			ST_SC_RD:  state_d = ST_SC_LD;
			ST_SC_LD:  state_d = ST_SC_DIV;
			ST_SC_DIV: if (div_rsp.done) state_d = ST_SC_WR;
			ST_SC_WR:  state_d = last_bin ? ST_BC : ST_SC_RD;
			ST_BC:     state_d = ST_PD_RD;
			ST_PD_RD:  state_d = ST_PD_LD;
			ST_PD_LD:  state_d = ST_SEARCH;
			ST_SEARCH: begin
				if ((hi_q - lo_q) <= 6'd1)
					state_d = norm_q ? ST_AD_DIV : ST_BN_RD;
			end
			ST_AD_DIV: if (div_rsp.done) state_d = ST_BN_RD;
			ST_BN_RD:  state_d = ST_BN_WR;
			ST_BN_WR:  state_d = ((j_q + 5'd1) == fill_q) ? ST_OUT_RD : ST_PD_RD;
			ST_OUT_RD: state_d = ST_OUT_LD;
			ST_OUT_LD: begin
				if (out_free)
					state_d = last_bin ? ST_IDLE : ST_OUT_RD;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		bin_raddr   = i_q[BIN_AW-1:0];
		bin_we      = 1'b0;
		bin_waddr   = i_q[BIN_AW-1:0];
		bin_wdata   = scaled[BIN_W-1:0];
		pend_raddr  = j_q[PEND_AW-1:0];
		out_load    = 1'b0;
		div_req     = '0;
		case (state_q)
			ST_SC_LD: begin
				div_req.start = 1'b1;
				div_req.num   = DVD_W'(bval);
				div_req.den   = DEN_W'(bc_q) + DEN_W'(1);
			end
			ST_SC_WR: bin_we = 1'b1;
			ST_SEARCH: begin
				if ((hi_q - lo_q) <= 6'd1 && norm_q) begin
					div_req.start = 1'b1;
					div_req.num   = DVD_W'($signed({wgt_q, 16'h0000}));
					div_req.den   = den_q;
				end
			end
			ST_BN_RD: bin_raddr = lo_q[BIN_AW-1:0];
			ST_BN_WR: begin
				bin_raddr = lo_q[BIN_AW-1:0];
				bin_we    = 1'b1;
				bin_waddr = lo_q[BIN_AW-1:0];
				bin_wdata = sat_sum;
			end
			ST_OUT_LD: out_load = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_min_q <= '0;
			bin_width_q <= 31'd65536;
			bins_q      <= 6'd32;
			batch_q     <= 5'd1;
			norm_q      <= 1'b1;
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			bc_q        <= '0;
			i_q         <= '0;
			j_q         <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			bin_vld_q   <= '0;
			m_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_acc) begin
				case (cfg_index)
					CFG_RANGE_MIN: range_min_q <= $signed(cfg_data);
					CFG_BIN_WIDTH: bin_width_q <= cfg_data[30:0];
					CFG_BINS:      bins_q      <= cfg_data[5:0];
					CFG_BATCH:     batch_q     <= cfg_data[4:0];
					CFG_NORMALIZE: norm_q      <= cfg_data[0];
					default: ;
				endcase
			end
			if (in_acc) begin
				fill_q <= fill_nx;
				i_q    <= '0;
			end
			if (bin_we)
				bin_vld_q[bin_waddr] <= 1'b1;
			case (state_q)
				ST_SC_WR: i_q <= i_q + 6'd1;
				ST_BC: begin
					bc_q <= bc_inc;
					j_q  <= '0;
				end
				ST_PD_LD: begin
					lo_q <= '0;
					hi_q <= n_eff;
				end
				ST_SEARCH: begin
					if ((hi_q - lo_q) > 6'd1) begin
						if (go_low)
							hi_q <= mid;
						else
							lo_q <= mid;
					end
				end
				ST_BN_WR: begin
					j_q <= j_q + 5'd1;
					if ((j_q + 5'd1) == fill_q) begin
						fill_q <= '0;
						i_q    <= '0;
					end
				end
				ST_OUT_LD: if (out_load) i_q <= i_q + 6'd1;
				default: ;
			endcase
			if (out_load)
				m_valid_q <= 1'b1;
			else if (m_axis_tready)
				m_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_SC_LD: acc_q <= bval;
			ST_PD_RD: den_q <= DEN_W'(fill_q * bc_q);
			ST_PD_LD: begin
				smp_q <= $signed(pend_rdata_s1[31:0]);
				wgt_q <= $signed(pend_rdata_s1[63:32]);
				elo_q <= 39'(range_min_q);
			end
			ST_SEARCH: begin
				if ((hi_q - lo_q) > 6'd1) begin
					if (!go_low)
						elo_q <= e_mid;
				end else if (!norm_q) begin
					add_q <= DVD_W'($signed({wgt_q, 16'h0000}));
				end
			end
			ST_AD_DIV: if (div_rsp.done) add_q <= div_rsp.quo;
			default: ;
		endcase
		if (out_load) begin
			m_data_q <= {3'b000, bc_q, bval, i_q[BIN_AW-1:0]};
			m_last_q <= last_bin;
		end
	end

	// bin store and sample buffer
	always_ff @(posedge clk) begin
		if (bin_we)
			bin_mem[bin_waddr] <= bin_wdata;
		bin_rdata_s1 <= bin_mem[bin_raddr];
		bin_rvld_s1  <= bin_vld_q[bin_raddr];
		if (in_acc && fill_q < 5'(MAX_BATCH))
			pend_mem[fill_q[PEND_AW-1:0]] <= s_axis_tdata;
		pend_rdata_s1 <= pend_mem[pend_raddr];
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tlast  = m_last_q;

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= 5'(MAX_BATCH))
		else $error("fill count beyond buffer depth");

	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_SC_DIV || state_q == ST_AD_DIV))
		else $error("divider finished outside a wait state");

	a_no_input_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !s_axis_tready)
		else $error("input taken during flush");

	a_bin_write_range: assert property (@(posedge clk) disable iff (!arst_n)
		bin_we |-> (6'(bin_waddr) < n_eff))
		else $error("bin write outside bins in use");

endmodule

FILE: src/wbh_div.sv
// Bit-serial signed divider, quotient rounded to nearest, ties away from zero.
// Depends on wbh_pkg.
module wbh_div (
	input  logic              clk,
	input  logic              arst_n,
	input  wbh_pkg::div_req_t req,
	output wbh_pkg::div_rsp_t rsp
);
	import wbh_pkg::*;

	logic [DVD_W-1:0] quo_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic             neg_q;
	logic [5:0]       cnt_q;
	logic             done_q;

	logic [DVD_W-1:0] mag;
	logic [DEN_W:0]   sh;
	logic [DEN_W:0]   diff;

	assign mag  = req.num[DVD_W-1] ? DVD_W'(-req.num) : DVD_W'(req.num);
	assign sh   = {rem_q, quo_q[DVD_W-1]};
	assign diff = sh - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= 6'(DVD_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1)
					done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			// bias by den/2 for round to nearest on the magnitude
			quo_q <= mag + DVD_W'(req.den >> 1);
			rem_q <= '0;
			den_q <= req.den;
			neg_q <= req.num[DVD_W-1];
		end else if (cnt_q != '0) begin
			if (!diff[DEN_W]) begin
				rem_q <= diff[DEN_W-1:0];
				quo_q <= {quo_q[DVD_W-2:0], 1'b1};
			end else begin
				rem_q <= sh[DEN_W-1:0];
				quo_q <= {quo_q[DVD_W-2:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = neg_q ? -$signed(quo_q) : $signed(quo_q);

endmodule
